### design/tlet_pkg.sv
// shared constants, request codes and control structs for the timed light event table
// no dependencies
package tlet_pkg;

	localparam int TLET_NUM_SLOTS = 16;
	localparam int TLET_TIME_BITS = 32;
	localparam int LIGHT_W        = 8;
	localparam int REQ_W          = 2;
	localparam int TIME_IN_W      = 32;

	localparam logic [REQ_W-1:0] REQ_ADD    = 2'd0;
	localparam logic [REQ_W-1:0] REQ_REMOVE = 2'd1;
	localparam logic [REQ_W-1:0] REQ_TICK   = 2'd2;

	// sequencer to head unit
	typedef struct packed {
		logic [REQ_W-1:0] req;
		logic             fill_pass;
		logic             hit;
	} tlet_ctl_t;

	// head unit back to sequencer
	typedef struct packed {
		logic hit;
		logic emit;
	} tlet_stat_t;

endpackage

### design/tlet_cell.sv
// one table entry of the rotating cell chain
// depends on tlet_pkg
module tlet_cell #(
	parameter int TIME_BITS = tlet_pkg::TLET_TIME_BITS
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        shift_en,
	input  logic                        d_used,
	input  logic [tlet_pkg::LIGHT_W-1:0] d_light,
	input  logic                        d_level,
	input  logic [TIME_BITS-1:0]        d_due,
	output logic                        q_used,
	output logic [tlet_pkg::LIGHT_W-1:0] q_light,
	output logic                        q_level,
	output logic [TIME_BITS-1:0]        q_due
);
	import tlet_pkg::*;

	logic                used_q;
	logic [LIGHT_W-1:0]  light_q;
	logic                level_q;
	logic [TIME_BITS-1:0] due_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= 1'b0;
		end else if (shift_en) begin
			used_q <= d_used;
		end
	end

	// payload only matters while the entry is in use
	always_ff @(posedge clk) begin
		if (shift_en) begin
			light_q <= d_light;
			level_q <= d_level;
			due_q   <= d_due;
		end
	end

	assign q_used  = used_q;
	assign q_light = light_q;
	assign q_level = level_q;
	assign q_due   = due_q;

endmodule

### design/tlet_head.sv
// compare and update logic applied to the entry at the head of the cell chain
// depends on tlet_pkg
module tlet_head #(
	parameter int TIME_BITS = tlet_pkg::TLET_TIME_BITS
) (
	input  tlet_pkg::tlet_ctl_t          ctl,
	input  logic [tlet_pkg::LIGHT_W-1:0] qry_light,
	input  logic                         qry_level,
	input  logic [TIME_BITS-1:0]         qry_time,
	input  logic                         e_used,
	input  logic [tlet_pkg::LIGHT_W-1:0] e_light,
	input  logic                         e_level,
	input  logic [TIME_BITS-1:0]         e_due,
	output logic                         n_used,
	output logic [tlet_pkg::LIGHT_W-1:0] n_light,
	output logic                         n_level,
	output logic [TIME_BITS-1:0]         n_due,
	output tlet_pkg::tlet_stat_t         stat
);
	import tlet_pkg::*;

	logic light_eq;
	logic due_eq;

	assign light_eq = (e_light == qry_light);
	assign due_eq   = (e_due == qry_time);

	always_comb begin
		n_used  = e_used;
		n_light = e_light;
		n_level = e_level;
		n_due   = e_due;
		stat    = '0;
		unique case (ctl.req)
			REQ_ADD: begin
				if (!ctl.hit) begin
					if (!ctl.fill_pass) begin
						// first pass: update an existing event in place
						if (e_used && light_eq && due_eq) begin
							n_level  = qry_level;
							stat.hit = 1'b1;
						end
					end else if (!e_used) begin
						// second pass: take the lowest free entry
						n_used   = 1'b1;
						n_light  = qry_light;
						n_level  = qry_level;
						n_due    = qry_time;
						stat.hit = 1'b1;
					end
				end
			end
			REQ_REMOVE: begin
				if (!ctl.hit && e_used && light_eq && (e_level == qry_level) && due_eq) begin
					n_used   = 1'b0;
					n_light  = '0;
					n_level  = 1'b0;
					n_due    = '0;
					stat.hit = 1'b1;
				end
			end
			REQ_TICK: begin
				if (e_used && due_eq) begin
					n_used    = 1'b0;
					n_light   = '0;
					n_level   = 1'b0;
					n_due     = '0;
					stat.emit = 1'b1;
				end
			end
			default: begin
				// unused code: entry passes unchanged
			end
		endcase
	end

endmodule

### design/timed_light_event_table_core.sv
// top level of the timed light event table: sequencer, head unit and cell chain
// depends on tlet_pkg, tlet_cell, tlet_head
//
// usage
//  - request channel (in_valid/in_ready) carries req_type, light_id, light_state,
//    event_time; add = 0, remove = 1, tick = 2, code 3 is ignored
//  - write channel (out_valid/out_ready) carries out_light, out_state, last_write,
//    one write per due entry on a tick, in ascending slot order
//  - the entries sit in a ring of NUM_SLOTS cells that rotates by one place per
//    unpaused scan cycle; the cell at the head passes the compare/update unit, so
//    one full revolution visits every slot once in slot order and leaves all in place
//  - sequence: a request is taken in the idle state only; remove, tick and
//    the unused code scan one revolution, an add one revolution when it
//    updates an existing event and a second one when it has to fill a free
//    entry; a tick then passes a flush state to hand out its final write
//  - each write of a tick passes the hold register, then the output
//    register; a due write is held back by one entry so last_write is known
//  - when the receiver stalls, the rotation pauses while a due entry finds a
//    write already held and the output register still full; the request side
//    waits meanwhile
//  - in_ready returns once the scan is done, for a tick once its final write
//    (if any) is loaded, even while that write still sits in the output register
//  - reset empties the table at once (valid bit per cell) and drops any
//    request or write in flight
module timed_light_event_table_core #(
	parameter int NUM_SLOTS = tlet_pkg::TLET_NUM_SLOTS,
	parameter int TIME_BITS = tlet_pkg::TLET_TIME_BITS
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [tlet_pkg::REQ_W-1:0]     req_type,
	input  logic [tlet_pkg::LIGHT_W-1:0]   light_id,
	input  logic                           light_state,
	input  logic [tlet_pkg::TIME_IN_W-1:0] event_time,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [tlet_pkg::LIGHT_W-1:0]   out_light,
	output logic                           out_state,
	output logic                           last_write
);
	import tlet_pkg::*;

	localparam int STEP_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FLUSH
	} state_t;

	state_t               state_q;
	logic [REQ_W-1:0]     req_q;
	logic [LIGHT_W-1:0]   light_q;
	logic                 level_q;
	logic [TIME_BITS-1:0] time_q;
	logic                 fill_q;
	logic                 hit_q;
	logic [STEP_W-1:0]    step_q;

	// one-deep hold of the latest due write of a tick
	logic                 pend_valid_q;
	logic [LIGHT_W-1:0]   pend_light_q;
	logic                 pend_level_q;

	// output register
	logic                 out_valid_q;
	logic [LIGHT_W-1:0]   out_light_q;
	logic                 out_state_q;
	logic                 out_last_q;

	// cell chain
	logic                 c_used  [NUM_SLOTS];
	logic [LIGHT_W-1:0]   c_light [NUM_SLOTS];
	logic                 c_level [NUM_SLOTS];
	logic [TIME_BITS-1:0] c_due   [NUM_SLOTS];

	logic                 h_used;
	logic [LIGHT_W-1:0]   h_light;
	logic                 h_level;
	logic [TIME_BITS-1:0] h_due;

	tlet_ctl_t            ctl;
	tlet_stat_t           stat;

	logic scan;
	logic out_load_ok;
	logic out_load;
	logic advance;
	logic last_step;
	logic hit_next;
	logic in_fire;

	assign in_ready    = (state_q == ST_IDLE);
	assign in_fire     = in_valid && in_ready;
	assign scan        = (state_q == ST_SCAN);
	assign out_load_ok = !out_valid_q || out_ready;
	// pause the ring when a due write would overrun the held one
	assign advance     = scan && !(stat.emit && pend_valid_q && !out_load_ok);
	assign last_step   = (step_q == STEP_W'(NUM_SLOTS - 1));
	assign hit_next    = hit_q || stat.hit;
	// output register takes the held write: a later due entry or the end of a tick
	assign out_load    = (advance && stat.emit && pend_valid_q) ||
		((state_q == ST_FLUSH) && pend_valid_q && out_load_ok);

	assign ctl.req       = req_q;
	assign ctl.fill_pass = fill_q;
	assign ctl.hit       = hit_q;

	tlet_head #(
		.TIME_BITS (TIME_BITS)
	) u_head (
		.ctl       (ctl),
		.qry_light (light_q),
		.qry_level (level_q),
		.qry_time  (time_q),
		.e_used    (c_used[0]),
		.e_light   (c_light[0]),
		.e_level   (c_level[0]),
		.e_due     (c_due[0]),
		.n_used    (h_used),
		.n_light   (h_light),
		.n_level   (h_level),
		.n_due     (h_due),
		.stat      (stat)
	);

	// the head's updated entry re-enters at the tail; every other cell takes its neighbor
	for (genvar i = 0; i < NUM_SLOTS; i++) begin : g_cell
		if (i == NUM_SLOTS - 1) begin : g_tail
			tlet_cell #(
				.TIME_BITS (TIME_BITS)
			) u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.shift_en (advance),
				.d_used   (h_used),
				.d_light  (h_light),
				.d_level  (h_level),
				.d_due    (h_due),
				.q_used   (c_used[i]),
				.q_light  (c_light[i]),
				.q_level  (c_level[i]),
				.q_due    (c_due[i])
			);
		end else begin : g_body
			tlet_cell #(
				.TIME_BITS (TIME_BITS)
			) u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.shift_en (advance),
				.d_used   (c_used[i+1]),
				.d_light  (c_light[i+1]),
				.d_level  (c_level[i+1]),
				.d_due    (c_due[i+1]),
				.q_used   (c_used[i]),
				.q_light  (c_light[i]),
				.q_level  (c_level[i]),
				.q_due    (c_due[i])
			);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			req_q        <= REQ_ADD;
			light_q      <= '0;
			level_q      <= 1'b0;
			time_q       <= '0;
			fill_q       <= 1'b0;
			hit_q        <= 1'b0;
			step_q       <= '0;
			pend_valid_q <= 1'b0;
			pend_light_q <= '0;
			pend_level_q <= 1'b0;
			out_valid_q  <= 1'b0;
			out_light_q  <= '0;
			out_state_q  <= 1'b0;
			out_last_q   <= 1'b0;
		end else begin
			// a new write, or the current one taken by the receiver
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						req_q   <= req_type;
						light_q <= light_id;
						level_q <= light_state;
						time_q  <= TIME_BITS'(event_time);
						fill_q  <= 1'b0;
						hit_q   <= 1'b0;
						step_q  <= '0;
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (advance) begin
						hit_q <= hit_next;
						if (stat.emit) begin
							// the held write is now known not to be the last
							if (pend_valid_q) begin
								out_light_q <= pend_light_q;
								out_state_q <= pend_level_q;
								out_last_q  <= 1'b0;
							end
							pend_valid_q <= 1'b1;
							pend_light_q <= c_light[0];
							pend_level_q <= c_level[0];
						end
						if (last_step) begin
							step_q <= '0;
							if (req_q == REQ_ADD && !fill_q && !hit_next) begin
								// no event to update: second revolution fills a free entry
								fill_q <= 1'b1;
							end else if (req_q == REQ_TICK) begin
								state_q <= ST_FLUSH;
							end else begin
								state_q <= ST_IDLE;
							end
						end else begin
							step_q <= step_q + STEP_W'(1);
						end
					end
				end
				ST_FLUSH: begin
					if (!pend_valid_q) begin
						state_q <= ST_IDLE;
					end else if (out_load_ok) begin
						out_light_q  <= pend_light_q;
						out_state_q  <= pend_level_q;
						out_last_q   <= 1'b1;
						pend_valid_q <= 1'b0;
						state_q      <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid  = out_valid_q;
	assign out_light  = out_light_q;
	assign out_state  = out_state_q;
	assign last_write = out_last_q;

endmodule

### design/tlet_checker.sv
// port-level checks for the timed light event table, bound to the top level
// depends on tlet_pkg and timed_light_event_table_core
module tlet_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         in_valid,
	input logic                         in_ready,
	input logic                         out_valid,
	input logic                         out_ready,
	input logic [tlet_pkg::LIGHT_W-1:0] out_light,
	input logic                         out_state,
	input logic                         last_write
);
	import tlet_pkg::*;

	// a stalled write holds its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_light) &&
			$stable(out_state) && $stable(last_write))
		else $error("write changed while stalled");

	// an accepted request leaves the block busy in the following cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request side ready right after a request");

	// no write appears out of an idle block
	a_no_spurious_write: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready && !in_valid && !out_valid |=> !out_valid)
		else $error("write appeared without a request");

endmodule

bind timed_light_event_table_core tlet_checker u_tlet_checker (.*);

### sim/testbench.sv
// self-checking testbench for timed_light_event_table_core: directed table, then random traffic
// keeps its own copy of the event table to predict every due write
// depends on tlet_pkg and the core
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import tlet_pkg::*;

	// request code with no meaning, the core must ignore it
	localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
	localparam int PLAN_ROWS = 24;

	typedef struct packed {
		logic [REQ_W-1:0]     kind;
		logic [LIGHT_W-1:0]   light;
		logic                 level;
		logic [TIME_IN_W-1:0] t;
	} sched_req_t;

	typedef struct packed {
		logic [LIGHT_W-1:0] light;
		logic               state;
		logic               last;
	} light_write_t;

	// one directed step; when typed is set the writes are given here (up to two)
	typedef struct packed {
		logic [REQ_W-1:0]     kind;
		logic [LIGHT_W-1:0]   light;
		logic                 level;
		logic [TIME_IN_W-1:0] t;
		logic                 typed;
		logic [1:0]           nexp;
		logic [LIGHT_W-1:0]   l0;
		logic                 s0;
		logic [LIGHT_W-1:0]   l1;
		logic                 s1;
	} plan_row_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	logic [REQ_W-1:0]     req_type = REQ_ADD;
	logic [LIGHT_W-1:0]   light_id = '0;
	logic                 light_state = 1'b0;
	logic [TIME_IN_W-1:0] event_time = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic [LIGHT_W-1:0]   out_light;
	logic                 out_state;
	logic                 last_write;

	// predicted event table
	logic                 ev_used  [TLET_NUM_SLOTS];
	logic [LIGHT_W-1:0]   ev_light [TLET_NUM_SLOTS];
	logic                 ev_level [TLET_NUM_SLOTS];
	logic [TIME_IN_W-1:0] ev_due   [TLET_NUM_SLOTS];

	light_write_t tick_writes[$];   // writes caused by the request just predicted
	light_write_t due_writes[$];    // writes still owed by the core, oldest first

	int mismatches  = 0;
	int items_sent  = 0;
	int burst_left  = 0;
	int rx_cycle    = 0;
	int rx_mode     = 0;

	plan_row_t plan [PLAN_ROWS];

	timed_light_event_table_core dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.req_type   (req_type),
		.light_id   (light_id),
		.light_state(light_state),
		.event_time (event_time),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_light  (out_light),
		.out_state  (out_state),
		.last_write (last_write)
	);

	// 2 ns clock
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// ---------------------------------------------------------------------------
	// table predictor
	// ---------------------------------------------------------------------------

	function automatic void free_entry(input int s);
		ev_used[s]  = 1'b0;
		ev_light[s] = '0;
		ev_level[s] = 1'b0;
		ev_due[s]   = '0;
	endfunction

	// applies one accepted request to the table, due writes land in tick_writes
	function automatic void schedule_step(input sched_req_t r);
		int hit;
		light_write_t wr;
		hit = -1;
		tick_writes = {};
		case (r.kind)
			REQ_ADD: begin
				// same light and time already scheduled: only the level changes
				for (int s = 0; s < TLET_NUM_SLOTS; s++)
					if (hit < 0 && ev_used[s] && ev_light[s] == r.light && ev_due[s] == r.t)
						hit = s;
				if (hit >= 0) begin
					ev_level[hit] = r.level;
				end else begin
					// lowest free entry, nothing happens when the table is full
					for (int s = 0; s < TLET_NUM_SLOTS; s++)
						if (hit < 0 && !ev_used[s])
							hit = s;
					if (hit >= 0) begin
						ev_used[hit]  = 1'b1;
						ev_light[hit] = r.light;
						ev_level[hit] = r.level;
						ev_due[hit]   = r.t;
					end
				end
			end
			REQ_REMOVE: begin
				for (int s = 0; s < TLET_NUM_SLOTS; s++)
					if (hit < 0 && ev_used[s] && ev_light[s] == r.light &&
						ev_level[s] == r.level && ev_due[s] == r.t)
						hit = s;
				if (hit >= 0)
					free_entry(hit);
			end
			REQ_TICK: begin
				// every occupied entry due now fires, in slot order, and is freed
				for (int s = 0; s < TLET_NUM_SLOTS; s++) begin
					if (ev_used[s] && ev_due[s] == r.t) begin
						wr.light = ev_light[s];
						wr.state = ev_level[s];
						wr.last  = 1'b0;
						tick_writes.push_back(wr);
						free_entry(s);
					end
				end
				if (tick_writes.size() > 0)
					tick_writes[tick_writes.size()-1].last = 1'b1;
			end
			default: begin
				// unused code: no effect
			end
		endcase
	endfunction

	// random occupied entry, or -1 on an empty table
	function automatic int pick_pending();
		int start;
		int found;
		start = $urandom_range(0, TLET_NUM_SLOTS-1);
		found = -1;
		for (int i = 0; i < TLET_NUM_SLOTS; i++)
			if (found < 0 && ev_used[(start + i) % TLET_NUM_SLOTS])
				found = (start + i) % TLET_NUM_SLOTS;
		return found;
	endfunction

	// mostly a handful of times so that adds, removes and ticks meet
	function automatic logic [TIME_IN_W-1:0] pick_time();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			2, 3, 4: return $urandom;
			default: return $urandom_range(0, 15);
		endcase
	endfunction

	function automatic sched_req_t mk_req(input logic [REQ_W-1:0] kind,
		input logic [LIGHT_W-1:0] light, input logic level, input logic [TIME_IN_W-1:0] t);
		sched_req_t r;
		r.kind  = kind;
		r.light = light;
		r.level = level;
		r.t     = t;
		return r;
	endfunction

	// ---------------------------------------------------------------------------
	// request side
	// ---------------------------------------------------------------------------

	// raise the request and hold it until the core takes it; called at a rising edge
	task automatic drive_request(input sched_req_t r);
		in_valid    <= 1'b1;
		req_type    <= r.kind;
		light_id    <= r.light;
		light_state <= r.level;
		event_time  <= r.t;
		do
			@(posedge clk);
		while (!in_ready);
		items_sent++;
	endtask

	// bursts of back-to-back requests, separated by random gaps
	task automatic sender_pause();
		int gap;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
				: $urandom_range(0, 8);
			gap = $urandom_range(1, 8);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic issue(input sched_req_t r);
		drive_request(r);
		schedule_step(r);
		foreach (tick_writes[i])
			due_writes.push_back(tick_writes[i]);
		sender_pause();
	endtask

	// hold off until every owed write has come out
	task automatic drain();
		in_valid <= 1'b0;
		while (due_writes.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic remove_pending();
		int s;
		s = pick_pending();
		if (s >= 0) begin
			// now and then the level is wrong, the remove must then miss
			if ($urandom_range(0, 3) == 0)
				issue(mk_req(REQ_REMOVE, ev_light[s], ~ev_level[s], ev_due[s]));
			else
				issue(mk_req(REQ_REMOVE, ev_light[s], ev_level[s], ev_due[s]));
		end
	endtask

	task automatic run_random();
		int base;
		int n;
		int s;
		logic [TIME_IN_W-1:0] t;
		logic [LIGHT_W-1:0] lt;
		base = items_sent;
		while (items_sent - base < 206) begin
			case ($urandom_range(0, 19))
				0, 1, 2, 3, 4, 5, 6, 7, 8: begin
					// a group of events on one time, perhaps a pending event removed, then its tick
					t  = pick_time();
					n  = $urandom_range(1, 6);
					lt = LIGHT_W'($urandom);
					for (int i = 0; i < n; i++) begin
						// sometimes the same light again, which updates its level
						if (i == 0 || $urandom_range(0, 3) != 0)
							lt = LIGHT_W'($urandom);
						issue(mk_req(REQ_ADD, lt, 1'($urandom_range(0, 1)), t));
					end
					if ($urandom_range(0, 2) == 0)
						remove_pending();
					issue(mk_req(REQ_TICK, LIGHT_W'($urandom), 1'($urandom_range(0, 1)), t));
				end
				9, 10, 11: remove_pending();
				12, 13: begin
					s = pick_pending();
					if (s >= 0)
						issue(mk_req(REQ_TICK, LIGHT_W'($urandom), 1'($urandom_range(0, 1)),
							ev_due[s]));
				end
				19: begin
					// overfill the table on one time, the extra adds are dropped
					t = pick_time();
					n = $urandom_range(17, 19);
					for (int i = 0; i < n; i++)
						issue(mk_req(REQ_ADD, LIGHT_W'($urandom), 1'($urandom_range(0, 1)), t));
					issue(mk_req(REQ_TICK, LIGHT_W'($urandom), 1'($urandom_range(0, 1)), t));
				end
				default: begin
					// noise, unused code included
					issue(mk_req(REQ_W'($urandom_range(0, 3)), LIGHT_W'($urandom),
						1'($urandom_range(0, 1)), pick_time()));
				end
			endcase
			if ($urandom_range(0, 24) == 0)
				drain();
		end
	endtask

	// ---------------------------------------------------------------------------
	// write side: stall pattern and checking
	// ---------------------------------------------------------------------------

	always @(posedge clk) begin
		light_write_t w;
		if (arst_n && out_valid && out_ready) begin
			if (due_writes.size() == 0) begin
				$error("unexpected write: out_light %0h out_state %0b last_write %0b",
					out_light, out_state, last_write);
				mismatches++;
			end else begin
				w = due_writes.pop_front();
				if (out_light !== w.light) begin
					$error("out_light: expected %0h, actual %0h", w.light, out_light);
					mismatches++;
				end
				if (out_state !== w.state) begin
					$error("out_state: expected %0b, actual %0b", w.state, out_state);
					mismatches++;
				end
				if (last_write !== w.last) begin
					$error("last_write: expected %0b, actual %0b", w.last, last_write);
					mismatches++;
				end
			end
		end
		// the stall pattern is redrawn among four modes: always ready, coin flip,
		// a periodic ready strobe, or long stalls
		rx_cycle++;
		if (rx_cycle % 50 == 0)
			rx_mode = $urandom_range(0, 3);
		case (rx_mode)
			0: out_ready <= 1'b1;
			1: out_ready <= 1'($urandom_range(0, 1));
			2: out_ready <= (rx_cycle % 4 == 0);
			default: out_ready <= (rx_cycle % 16 >= 12);
		endcase
	end

	// ---------------------------------------------------------------------------
	// main sequence
	// ---------------------------------------------------------------------------

	initial begin
		sched_req_t r;
		light_write_t w;
		// kind, light, level, time, typed, count, first write, second write
		plan = '{
			// empty table: a tick on time 0 must not fire freed entries
			{REQ_TICK,   8'h00, 1'b0, 32'h0000_0000, 1'b1, 2'd0, 8'h00, 1'b0, 8'h00, 1'b0},
			{REQ_ADD,    8'h00, 1'b0, 32'h0000_0000, 1'b1, 2'd0, 8'h00, 1'b0, 8'h00, 1'b0},
			{REQ_TICK,   8'h00, 1'b0, 32'h0000_0000, 1'b1, 2'd1, 8'h00, 1'b0, 8'h00, 1'b0},
			// top light and time, then a level update on the same entry
			{REQ_ADD,    8'hFF, 1'b1, 32'hFFFF_FFFF, 1'b0, 2'd0, 8'h00, 1'b0, 8'h00, 1'b0},
			{REQ_ADD,    8'hFF, 1'b0, 32'hFFFF_FFFF, 1'b0, 2'd0, 8'h00, 1'b0, 8'h00, 1'b0},
			{REQ_TICK,   8'h00, 1'b1, 32'hFFFF_FFFF, 1'b1, 2'd1, 8'hFF, 1'b0, 8'h00, 1'b0},
			// removes that miss on level and on time, then one that hits
			{REQ_ADD,    8'h0A, 1'b1, 32'h0000_0005, 1'b0, 2'd0, 8'h00, 1'b0, 8'h00, 1'b0},
			{REQ_REMOVE, 8'h0A, 1'b0, 32'h0000_0005, 1'b0, 2'd0, 8'h00, 1'b0, 8'h00, 1'b0},
			{REQ_REMOVE, 8'h0A, 1'b1, 32'h0000_0006, 1'b0, 2'd0, 8'h00, 1'b0, 8'h00, 1'b0},
			{REQ_REMOVE, 8'h0A, 1'b1, 32'h0000_0005, 1'b0, 2'd0, 8'h00, 1'b0, 8'h00, 1'b0},
			{REQ_TICK,   8'hFF, 1'b0, 32'h0000_0005, 1'b1, 2'd0, 8'h00, 1'b0, 8'h00, 1'b0},
			// two due entries on one tick, a third on a neighbor time
			{REQ_ADD,    8'h01, 1'b1, 32'h8000_0000, 1'b0, 2'd0, 8'h00, 1'b0, 8'h00, 1'b0},
			{REQ_ADD,    8'h02, 1'b0, 32'h8000_0000, 1'b0, 2'd0, 8'h00, 1'b0, 8'h00, 1'b0},
			{REQ_ADD,    8'h01, 1'b1, 32'h7FFF_FFFF, 1'b0, 2'd0, 8'h00, 1'b0, 8'h00, 1'b0},
			// unused code must leave the table alone
			{REQ_UNUSED, 8'h02, 1'b0, 32'h8000_0000, 1'b0, 2'd0, 8'h00, 1'b0, 8'h00, 1'b0},
			{REQ_TICK,   8'h00, 1'b0, 32'h8000_0000, 1'b1, 2'd2, 8'h01, 1'b1, 8'h02, 1'b0},
			{REQ_TICK,   8'h00, 1'b0, 32'h7FFF_FFFF, 1'b0, 2'd0, 8'h00, 1'b0, 8'h00, 1'b0},
			{REQ_ADD,    8'hAA, 1'b1, 32'h5555_5555, 1'b0, 2'd0, 8'h00, 1'b0, 8'h00, 1'b0},
			{REQ_REMOVE, 8'hAA, 1'b1, 32'h5555_5555, 1'b0, 2'd0, 8'h00, 1'b0, 8'h00, 1'b0},
			{REQ_TICK,   8'hAA, 1'b1, 32'h5555_5555, 1'b1, 2'd0, 8'h00, 1'b0, 8'h00, 1'b0},
			{REQ_ADD,    8'h55, 1'b0, 32'hAAAA_AAAA, 1'b0, 2'd0, 8'h00, 1'b0, 8'h00, 1'b0},
			{REQ_ADD,    8'h55, 1'b1, 32'hAAAA_AAAA, 1'b0, 2'd0, 8'h00, 1'b0, 8'h00, 1'b0},
			{REQ_TICK,   8'h55, 1'b0, 32'hAAAA_AAAA, 1'b0, 2'd0, 8'h00, 1'b0, 8'h00, 1'b0},
			// freed entries are back to zero but must not fire
			{REQ_TICK,   8'h00, 1'b0, 32'h0000_0000, 1'b1, 2'd0, 8'h00, 1'b0, 8'h00, 1'b0}
		};
		for (int s = 0; s < TLET_NUM_SLOTS; s++)
			free_entry(s);

		// reset held low from the start, released at an edge
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table; typed rows give their writes, the rest go to the predictor
		foreach (plan[i]) begin
			r = mk_req(plan[i].kind, plan[i].light, plan[i].level, plan[i].t);
			drive_request(r);
			schedule_step(r);
			if (plan[i].typed) begin
				if (plan[i].nexp == 2'd1) begin
					w.light = plan[i].l0;
					w.state = plan[i].s0;
					w.last  = 1'b1;
					due_writes.push_back(w);
				end else if (plan[i].nexp == 2'd2) begin
					w.light = plan[i].l0;
					w.state = plan[i].s0;
					w.last  = 1'b0;
					due_writes.push_back(w);
					w.light = plan[i].l1;
					w.state = plan[i].s1;
					w.last  = 1'b1;
					due_writes.push_back(w);
				end
			end else begin
				foreach (tick_writes[j])
					due_writes.push_back(tick_writes[j]);
			end
			sender_pause();
		end
		drain();

		run_random();

		// everything owed must arrive, then a quiet spell for stray writes
		drain();
		repeat (40) @(posedge clk);
		if (mismatches == 0 && due_writes.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	// run limit, far above the slowest correct run
	initial begin
		#2000000;
		$display("Mismatches found");
		$finish;
	end

endmodule
